[hw/rtl/aoet_pkg.sv]
// Shared types and codes of the overlap event tracker.
// Holds register indexes, alignment and event codes, and inter-module structs.
// No dependencies.
package aoet_pkg;

  // Field widths fixed by the item and register formats
  localparam int ID_W    = 5;
  localparam int SIZE_W  = 15;
  localparam int OFF_W   = SIZE_W + 2;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRACKING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_W     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_H     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EVT_MASK  = 3'd7;

  // Box alignment modes
  localparam logic [2:0] ALIGN_CENTER = 3'd0;
  localparam logic [2:0] ALIGN_TOP    = 3'd1;
  localparam logic [2:0] ALIGN_BOTTOM = 3'd2;
  localparam logic [2:0] ALIGN_LEFT   = 3'd3;
  localparam logic [2:0] ALIGN_RIGHT  = 3'd4;

  // Input opcodes
  localparam logic OP_CANDIDATE = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  // Event kinds
  localparam logic [KIND_W-1:0] EVT_ENTER = 2'd0;
  localparam logic [KIND_W-1:0] EVT_STAY  = 2'd1;
  localparam logic [KIND_W-1:0] EVT_EXIT  = 2'd2;
  localparam logic [KIND_W-1:0] EVT_DONE  = 2'd3;

  // Event mask bits
  localparam int MASK_ENTER = 0;
  localparam int MASK_STAY  = 1;
  localparam int MASK_EXIT  = 2;

  // Settings the front needs for box placement and filtering
  typedef struct packed {
    logic                    tracking;
    logic [ID_W-1:0]         own_id;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic [SIZE_W-1:0]       box_w;
    logic [SIZE_W-1:0]       box_h;
  } front_cfg_t;

  // Settings the back needs for reporting
  typedef struct packed {
    logic       tracking;
    logic [2:0] event_mask;
  } back_cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic            is_end;
    logic [ID_W-1:0] id;
  } cmd_t;

endpackage

[hw/rtl/aoet_in_if.sv]
// Input item channel of the overlap event tracker.
// Carries valid/ready and the candidate or frame-end payload; uses aoet_pkg.
interface aoet_in_if
  import aoet_pkg::*;
#(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] own_x;
  logic signed [COORD_BITS-1:0] own_y;
  logic [ID_W-1:0]              other_id;
  logic signed [COORD_BITS-1:0] other_x;
  logic signed [COORD_BITS-1:0] other_y;
  logic [SIZE_W-1:0]            other_width;
  logic [SIZE_W-1:0]            other_height;

  modport source (
    output valid, opcode, own_x, own_y, other_id, other_x, other_y,
           other_width, other_height,
    input  ready
  );

  modport sink (
    input  valid, opcode, own_x, own_y, other_id, other_x, other_y,
           other_width, other_height,
    output ready
  );
endinterface

[hw/rtl/aoet_out_if.sv]
// Result item channel of the overlap event tracker.
// Carries valid/ready and the event payload; uses aoet_pkg.
interface aoet_out_if
  import aoet_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ID_W-1:0]   object_id;
  logic              last;

  modport source (output valid, event_kind, object_id, last, input ready);
  modport sink   (input valid, event_kind, object_id, last, output ready);
endinterface

[hw/rtl/aabb_overlap_event_tracker.sv]
// Overlap event tracker for one axis-aligned collision box. Candidate items
// are taken one per cycle unless a full command queue holds the front; a hit
// passes stage A and the queue into the result register; a missed or filtered
// candidate costs no back-end time. A frame-end item holds the back end while it
// is taken, for the exit scan over every object id, and for the done marker
// (no scan while tracking is off). A four-entry command queue lets candidates
// keep streaming during that scan until it fills. Configuration writes take
// effect on the next cycle; the user must make them while no item is in flight,
// which the block never checks. Depends on aoet_pkg and the channel interfaces.
module aabb_overlap_event_tracker
  import aoet_pkg::*;
#(
  parameter int MAX_OBJECTS = 32,
  parameter int COORD_BITS  = 16
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  aoet_in_if.sink               items_in,
  aoet_out_if.source            events_out
);

  logic              tracking;
  logic [ID_W-1:0]   own_id;
  logic [SIZE_W-1:0] tex_w;
  logic [SIZE_W-1:0] tex_h;
  logic [SIZE_W-1:0] box_w;
  logic [SIZE_W-1:0] box_h;
  logic [2:0]        alignment;
  logic [2:0]        event_mask;

  logic signed [OFF_W-1:0] diff_x;
  logic signed [OFF_W-1:0] diff_y;
  logic signed [OFF_W-1:0] half_x;
  logic signed [OFF_W-1:0] half_y;

  front_cfg_t fcfg;
  back_cfg_t  bcfg;
  cmd_t       push_cmd;
  logic       push_valid;
  logic       push_ready;
  cmd_t       pop_cmd;
  logic       pop_valid;
  logic       pop_ready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking   <= 1'b1;
      own_id     <= '0;
      tex_w      <= '0;
      tex_h      <= '0;
      box_w      <= '0;
      box_h      <= '0;
      alignment  <= ALIGN_CENTER;
      event_mask <= 3'b111;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_TRACKING:  tracking   <= cfg_data[0];
        REG_OWN_ID:    own_id     <= cfg_data[ID_W-1:0];
        REG_TEX_W:     tex_w      <= cfg_data[SIZE_W-1:0];
        REG_TEX_H:     tex_h      <= cfg_data[SIZE_W-1:0];
        REG_BOX_W:     box_w      <= cfg_data[SIZE_W-1:0];
        REG_BOX_H:     box_h      <= cfg_data[SIZE_W-1:0];
        REG_ALIGNMENT: alignment  <= cfg_data[2:0];
        REG_EVT_MASK:  event_mask <= cfg_data[2:0];
        default:       tracking   <= tracking;
      endcase
    end
  end

  // Box offset inside the texture; halves round toward minus infinity
  assign diff_x = signed'({2'b00, tex_w}) - signed'({2'b00, box_w});
  assign diff_y = signed'({2'b00, tex_h}) - signed'({2'b00, box_h});
  assign half_x = diff_x >>> 1;
  assign half_y = diff_y >>> 1;

  always_comb begin
    fcfg.tracking = tracking;
    fcfg.own_id   = own_id;
    fcfg.box_w    = box_w;
    fcfg.box_h    = box_h;
    unique case (alignment)
      ALIGN_TOP: begin
        fcfg.off_x = half_x;
        fcfg.off_y = '0;
      end
      ALIGN_BOTTOM: begin
        fcfg.off_x = half_x;
        fcfg.off_y = diff_y;
      end
      ALIGN_LEFT: begin
        fcfg.off_x = '0;
        fcfg.off_y = half_y;
      end
      ALIGN_RIGHT: begin
        fcfg.off_x = diff_x;
        fcfg.off_y = half_y;
      end
      default: begin
        fcfg.off_x = half_x;
        fcfg.off_y = half_y;
      end
    endcase
  end

  assign bcfg.tracking   = tracking;
  assign bcfg.event_mask = event_mask;

  aoet_front #(
    .COORD_BITS  (COORD_BITS),
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (fcfg),
    .items_in   (items_in),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  aoet_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  aoet_back #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (bcfg),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .events_out (events_out)
  );

endmodule

[hw/rtl/aoet_queue.sv]
// Short command queue between the classifying front and the reporting back.
// Depth from aoet_pkg; push and pop may happen in the same cycle.
module aoet_queue
  import aoet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

endmodule

[hw/rtl/aoet_front.sv]
// Front of the overlap event tracker: accepts items, places the own box,
// runs the strict overlap test and queues hits and frame ends. Uses aoet_pkg.
module aoet_front
  import aoet_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int MAX_OBJECTS = 32
)(
  input  logic       clk,
  input  logic       rst,
  input  front_cfg_t cfg,
  aoet_in_if.sink    items_in,
  output cmd_t       push_cmd,
  output logic       push_valid,
  input  logic       push_ready
);

  // Sum width covers position plus offset plus size without overflow
  localparam int SW = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 2;

  logic                 a_valid;
  logic                 a_end;
  logic [ID_W-1:0]      a_id;
  logic signed [SW-1:0] a_ax;
  logic signed [SW-1:0] a_ay;
  logic signed [SW-1:0] a_bx;
  logic signed [SW-1:0] a_by;
  logic signed [SW-1:0] a_bxe;
  logic signed [SW-1:0] a_bye;

  logic                 accept;
  logic                 keep;
  logic                 advance;
  logic                 hit;
  logic signed [SW-1:0] w_ext;
  logic signed [SW-1:0] h_ext;

  // Drop candidates that cannot matter before they enter the pipeline
  assign keep = (items_in.opcode == OP_FRAME_END) ||
                (cfg.tracking && (items_in.other_id != cfg.own_id) &&
                 (int'(items_in.other_id) < MAX_OBJECTS));

  assign accept  = items_in.valid && items_in.ready;
  assign advance = !a_valid || !push_valid || push_ready;
  assign items_in.ready = advance;

  // Stage A: place own box and find candidate's far edges
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_end <= (items_in.opcode == OP_FRAME_END);
      a_id  <= items_in.other_id;
      a_ax  <= SW'(items_in.own_x) + SW'(cfg.off_x);
      a_ay  <= SW'(items_in.own_y) + SW'(cfg.off_y);
      a_bx  <= SW'(items_in.other_x);
      a_by  <= SW'(items_in.other_y);
      a_bxe <= SW'(items_in.other_x) + SW'(signed'({1'b0, items_in.other_width}));
      a_bye <= SW'(items_in.other_y) + SW'(signed'({1'b0, items_in.other_height}));
    end
  end

  // Stage B: strict overlap on every edge of both boxes, combinational from stage A
  assign w_ext = SW'(signed'({1'b0, cfg.box_w}));
  assign h_ext = SW'(signed'({1'b0, cfg.box_h}));
  assign hit   = (a_ax < a_bxe) && ((a_ax + w_ext) > a_bx) &&
                 (a_ay < a_bye) && ((a_ay + h_ext) > a_by);

  assign push_valid      = a_valid && (a_end || hit);
  assign push_cmd.is_end = a_end;
  assign push_cmd.id     = a_id;

endmodule

[hw/rtl/aoet_back.sv]
// Back of the overlap event tracker: keeps the overlap bitmaps, reports
// enter/stay, scans exits at frame end and emits the done marker. Uses aoet_pkg.
module aoet_back
  import aoet_pkg::*;
#(
  parameter int MAX_OBJECTS = 32
)(
  input  logic       clk,
  input  logic       rst,
  input  back_cfg_t  cfg,
  input  cmd_t       pop_cmd,
  input  logic       pop_valid,
  output logic       pop_ready,
  aoet_out_if.source events_out
);

  localparam int IDX_W = $clog2(MAX_OBJECTS);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                 state;
  logic [MAX_OBJECTS-1:0] prev_map;
  logic [MAX_OBJECTS-1:0] cur_map;
  logic [IDX_W-1:0]       idx;
  logic                   o_valid;
  logic [KIND_W-1:0]      o_kind;
  logic [ID_W-1:0]        o_id;
  logic                   o_last;

  logic                   slot_free;
  logic [MAX_OBJECTS-1:0] sel;
  logic                   was;
  logic                   gone;
  logic                   report;
  logic                   load;
  logic                   o_valid_next;

  assign slot_free = !o_valid || events_out.ready;
  assign pop_ready = (state == ST_IDLE) && slot_free;

  // Decode candidate id to its bitmap position
  always_comb begin
    for (int i = 0; i < MAX_OBJECTS; i++) begin
      sel[i] = (int'(pop_cmd.id) == i);
    end
  end

  assign was    = |(prev_map & sel);
  assign gone   = prev_map[idx] && !cur_map[idx];
  assign report = was ? cfg.event_mask[MASK_STAY] : cfg.event_mask[MASK_ENTER];

  // Decide whether the current state produces a result item
  always_comb begin
    unique case (state)
      ST_IDLE: load = pop_valid && !pop_cmd.is_end && report;
      ST_SCAN: load = gone && cfg.event_mask[MASK_EXIT];
      ST_DONE: load = 1'b1;
      default: load = 1'b0;
    endcase
  end

  // Load a new result when the slot frees, otherwise hold until taken
  assign o_valid_next = (slot_free && load) || (o_valid && !events_out.ready);

  // Sequence commands and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      o_valid  <= 1'b0;
      prev_map <= '0;
      cur_map  <= '0;
      idx      <= '0;
    end else begin
      o_valid <= o_valid_next;
      unique case (state)
        ST_IDLE: begin
          if (pop_valid && slot_free) begin
            if (pop_cmd.is_end) begin
              idx   <= '0;
              state <= cfg.tracking ? ST_SCAN : ST_DONE;
            end else begin
              cur_map <= cur_map | sel;
              if (report) begin
                o_kind  <= was ? EVT_STAY : EVT_ENTER;
                o_id    <= pop_cmd.id;
                o_last  <= 1'b1;
              end
            end
          end
        end
        ST_SCAN: begin
          if (slot_free) begin
            if (load) begin
              o_kind  <= EVT_EXIT;
              o_id    <= ID_W'(idx);
              o_last  <= 1'b0;
            end
            if (idx == IDX_W'(MAX_OBJECTS - 1)) begin
              state <= ST_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            o_kind  <= EVT_DONE;
            o_id    <= '0;
            o_last  <= 1'b1;
            if (cfg.tracking) begin
              prev_map <= cur_map;
              cur_map  <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign events_out.valid      = o_valid;
  assign events_out.event_kind = o_kind;
  assign events_out.object_id  = o_id;
  assign events_out.last       = o_last;

endmodule

[hw/rtl/aoet_checker.sv]
// Port-level checks of the overlap event tracker's result channel.
// Bound to aabb_overlap_event_tracker; uses aoet_pkg event codes.
module aoet_checker
  import aoet_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [ID_W-1:0]   out_id,
  input logic              out_last
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
                                $stable(out_id) && $stable(out_last))
    else $error("result changed while stalled");

  // Done marker carries id zero and closes the item
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == EVT_DONE) |-> (out_id == '0) && out_last)
    else $error("malformed frame done marker");

  // Exits never close an item; enter and stay always do
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind != EVT_EXIT)))
    else $error("last flag does not match event kind");

  // No result straight out of reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind aabb_overlap_event_tracker aoet_checker u_aoet_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (events_out.valid),
  .out_ready (events_out.ready),
  .out_kind  (events_out.event_kind),
  .out_id    (events_out.object_id),
  .out_last  (events_out.last)
);
